FILE: hdl/eckf_pkg.sv
// Shared types, constants and helper functions of the elevation cell fusion block.
package eckf_pkg;

  localparam int unsigned GRID_X_DEF = 64;
  localparam int unsigned GRID_Y_DEF = 64;
  localparam logic [31:0] MEAS_VAR_MIN_DEF = 32'd1678;
  localparam logic [31:0] MEAS_VAR_MAX_DEF = 32'd16777216;

  // Widest cell index that any legal grid size needs (1024 by 1024 cells).
  localparam int CELL_IDX_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [31:0] X_ORIGIN_RST = -32'sd327680;
  localparam logic signed [31:0] Y_ORIGIN_RST = -32'sd327680;
  localparam logic [31:0] CELLS_PER_METRE_RST = 32'd655360;
  localparam logic [15:0] GATE_THRESHOLD_RST = 16'd640;
  localparam logic        GATE_USES_MEAS_RST = 1'b1;
  localparam logic [31:0] OUTLIER_NOISE_RST = 32'd167772;
  localparam logic [31:0] MAP_VAR_MIN_RST = 32'd1678;
  localparam logic [31:0] MAP_VAR_MAX_RST = 32'd16777216;

  typedef enum logic [1:0] {
    MODE_FUSE   = 2'd0,
    MODE_PRUNE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_SEEDED  = 3'd0,
    ST_FUSED   = 3'd1,
    ST_OUTLIER = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_PRUNED  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN       = 3'd0,
    CFG_Y_ORIGIN       = 3'd1,
    CFG_CELLS_PER_M    = 3'd2,
    CFG_GATE_THRESHOLD = 3'd3,
    CFG_GATE_USES_MEAS = 3'd4,
    CFG_OUTLIER_NOISE  = 3'd5,
    CFG_MAP_VAR_MIN    = 3'd6,
    CFG_MAP_VAR_MAX    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    K_FUSE    = 2'd0,
    K_OUTSIDE = 2'd1,
    K_PRUNE   = 2'd2,
    K_CLEAR   = 2'd3
  } job_kind_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_RD,
    B_GATE,
    B_MUL,
    B_CMP,
    B_DIV,
    B_UPD,
    B_SW_RD,
    B_SW_CHK,
    B_SW_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        meas_variance;
    logic [31:0]        stamp;
    logic [31:0]        max_age;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [11:0]        cell_index;
    logic signed [31:0] cell_height;
    logic [31:0]        cell_variance;
    logic [15:0]        cell_count;
    logic [12:0]        cells_emptied;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [31:0]        cells_per_metre;
    logic [15:0]        gate_threshold;
    logic               gate_uses_measurement;
    logic [31:0]        outlier_noise;
    logic [31:0]        map_var_min;
    logic [31:0]        map_var_max;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    job_kind_t              kind;
    logic [CELL_IDX_W-1:0]  idx;
    logic signed [31:0]     zm;
    logic [31:0]            vm;
    logic [31:0]            stamp;
    logic [31:0]            max_age;
  } job_t;

  // Raise to the lower bound first, then cut to the upper bound.
  function automatic logic [31:0] clamp_var(input logic [32:0] v, input logic [31:0] lo,
                                            input logic [31:0] hi);
    logic [32:0] t;
    t = (v < {1'b0, lo}) ? {1'b0, lo} : v;
    if (t > {1'b0, hi}) begin
      t = {1'b0, hi};
    end
    return t[31:0];
  endfunction

endpackage

FILE: hdl/eckf_front.sv
// Front end: accepts items, maps points to cells and classifies them into jobs.
module eckf_front #(
  parameter int unsigned GRID_X = eckf_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = eckf_pkg::GRID_Y_DEF,
  parameter logic [31:0] MEAS_VAR_MIN = eckf_pkg::MEAS_VAR_MIN_DEF,
  parameter logic [31:0] MEAS_VAR_MAX = eckf_pkg::MEAS_VAR_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  eckf_pkg::cfg_t     cfg,
  input  logic               hold,
  input  logic               push,
  output logic               full,
  input  eckf_pkg::in_item_t in_item,
  output logic               q_push,
  output eckf_pkg::job_t     q_data,
  input  logic               q_full
);

  localparam int unsigned NCELLS = GRID_X * GRID_Y;
  localparam int IDX_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;

  logic               a_valid_r, a_valid_nxt;
  eckf_pkg::in_item_t a_item_r;
  logic               b_valid_r, b_valid_nxt;
  eckf_pkg::in_item_t b_item_r;
  logic               b_negx_r, b_negy_r;
  logic [47:0]        b_hx_r, b_lx_r, b_hy_r, b_ly_r;

  logic        b_adv, b_ready, a_adv, in_acc;
  logic [32:0] dx, dy;
  logic [47:0] hx, lx, hy, ly;
  logic [48:0] sumx, sumy;
  logic [32:0] cx, cy;
  logic        outside;
  logic [IDX_W-1:0] ixw, iyw, idx;
  logic [31:0] vm_lo;

  assign b_adv   = b_valid_r && !q_full;
  assign b_ready = !b_valid_r || b_adv;
  assign a_adv   = a_valid_r && b_ready;
  assign full    = hold || (a_valid_r && !b_ready);
  assign in_acc  = push && !full;

  // Offsets from the grid origin, exact in 33 bits; nonnegative ones fit in 32.
  assign dx = {a_item_r.point_x[31], a_item_r.point_x} - {cfg.x_origin[31], cfg.x_origin};
  assign dy = {a_item_r.point_y[31], a_item_r.point_y} - {cfg.y_origin[31], cfg.y_origin};
  assign hx = dx[31:16] * cfg.cells_per_metre;
  assign lx = dx[15:0] * cfg.cells_per_metre;
  assign hy = dy[31:16] * cfg.cells_per_metre;
  assign ly = dy[15:0] * cfg.cells_per_metre;

  assign sumx = {1'b0, b_hx_r} + {17'b0, b_lx_r[47:16]};
  assign sumy = {1'b0, b_hy_r} + {17'b0, b_ly_r[47:16]};
  assign cx = sumx[48:16];
  assign cy = sumy[48:16];
  assign outside = b_negx_r || b_negy_r || (cx >= 33'(GRID_X)) || (cy >= 33'(GRID_Y));
  assign ixw = cx[IDX_W-1:0];
  assign iyw = cy[IDX_W-1:0];
  assign idx = IDX_W'(ixw * IDX_W'(GRID_Y) + iyw);

  assign vm_lo = (b_item_r.meas_variance < MEAS_VAR_MIN) ? MEAS_VAR_MIN
                                                         : b_item_r.meas_variance;

  always_comb begin
    q_push = b_adv;
    q_data.idx = eckf_pkg::CELL_IDX_W'(idx);
    q_data.zm = b_item_r.point_z;
    q_data.vm = (vm_lo > MEAS_VAR_MAX) ? MEAS_VAR_MAX : vm_lo;
    q_data.stamp = b_item_r.stamp;
    q_data.max_age = b_item_r.max_age;
    case (eckf_pkg::mode_t'(b_item_r.mode))
      eckf_pkg::MODE_PRUNE: begin
        q_data.kind = eckf_pkg::K_PRUNE;
      end
      eckf_pkg::MODE_CLEAR: begin
        q_data.kind = eckf_pkg::K_CLEAR;
      end
      default: begin
        q_data.kind = outside ? eckf_pkg::K_OUTSIDE : eckf_pkg::K_FUSE;
      end
    endcase
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      // Items of the unused mode are dropped right here.
      a_valid_nxt = (eckf_pkg::mode_t'(in_item.mode) != eckf_pkg::MODE_IGNORE);
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (a_adv) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
    if (in_acc) begin
      a_item_r <= in_item;
    end
    if (a_adv) begin
      b_item_r <= a_item_r;
      b_negx_r <= dx[32];
      b_negy_r <= dy[32];
      b_hx_r <= hx;
      b_lx_r <= lx;
      b_hy_r <= hy;
      b_ly_r <= ly;
    end
  end

endmodule

FILE: hdl/eckf_queue.sv
// Short job queue that decouples the front end from the cell update engine.
module eckf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eckf_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output eckf_pkg::job_t head
);

  localparam int DEPTH = eckf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  eckf_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/eckf_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^33.
module eckf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] num,
  input  logic [32:0] den,
  output logic        busy,
  output logic [32:0] quot
);

  localparam int QW = 33;
  localparam int STEP_W = $clog2(QW + 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [32:0]       rem_r, rem_nxt;
  logic [32:0]       nq_r, nq_nxt;
  logic [33:0]       sh, diff;

  assign busy = busy_r;
  assign quot = nq_r;
  // The remaining numerator bits leave at the top while quotient bits enter below.
  assign sh   = {rem_r, nq_r[32]};
  assign diff = sh - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt = rem_r;
    nq_nxt = nq_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt = {1'b0, num[64:33]};
      nq_nxt = num[32:0];
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        nq_nxt = {nq_r[31:0], 1'b1};
      end else begin
        rem_nxt = sh[32:0];
        nq_nxt = {nq_r[31:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    nq_r <= nq_nxt;
  end

endmodule

FILE: hdl/eckf_back.sv
// Back end: cell stores, gate, Kalman update, prune and clear sweeps, result register.
module eckf_back #(
  parameter int unsigned GRID_X = eckf_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = eckf_pkg::GRID_Y_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  eckf_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  eckf_pkg::job_t      q_data,
  output logic                q_pop,
  output logic                init_busy,
  output logic                empty,
  input  logic                pop,
  output eckf_pkg::out_item_t out_item
);

  localparam int unsigned NCELLS = GRID_X * GRID_Y;
  localparam int IDX_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int EMP_W = $clog2(NCELLS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NCELLS - 1);

  eckf_pkg::back_state_t state_r, state_nxt;
  eckf_pkg::job_t        job_r;
  logic [IDX_W-1:0]      swp_r, swp_nxt;
  logic [EMP_W-1:0]      emp_r, emp_nxt;

  logic [31:0] h_mem [NCELLS];
  logic [31:0] v_mem [NCELLS];
  logic [31:0] s_mem [NCELLS];
  logic [15:0] c_mem [NCELLS];
  logic [31:0] rd_h_r, rd_v_r, rd_s_r;
  logic [15:0] rd_c_r;

  logic        neg_r;
  logic [31:0] mag_r, thr2_r;
  logic [32:0] s_r, vsum_r;
  logic [63:0] lhs_r, pz_r, pv_r;
  logic [64:0] rhs_r;

  logic                out_valid_r;
  eckf_pkg::out_item_t out_item_r;

  logic [IDX_W-1:0] addr;
  logic        mem_re, mem_we, cnt_we;
  logic [31:0] wr_h, wr_v, wr_s;
  logic [15:0] wr_c;
  logic        res_ok, res_we;
  eckf_pkg::out_item_t res_item;

  logic [32:0] dz, g, s_val;
  logic [31:0] mag;
  logic        pass, stale, kill;
  logic [15:0] cnt_inc;
  logic        div_start, z_busy, v_busy;
  logic [64:0] numz, numv;
  logic [32:0] quot_z, quot_v, qv;
  logic [31:0] qz, zn;

  assign init_busy = (state_r == eckf_pkg::B_INIT);
  assign empty     = !out_valid_r;
  assign out_item  = out_item_r;
  assign res_ok    = !out_valid_r || pop;

  assign addr = (state_r == eckf_pkg::B_INIT || state_r == eckf_pkg::B_SW_RD ||
                 state_r == eckf_pkg::B_SW_CHK) ? swp_r : job_r.idx[IDX_W-1:0];

  // Gate terms, formed from the freshly read cell.
  assign dz    = {job_r.zm[31], job_r.zm} - {rd_h_r[31], rd_h_r};
  assign mag   = dz[32] ? 32'(-dz) : dz[31:0];
  assign g     = {1'b0, rd_v_r} + (cfg.gate_uses_measurement ? {1'b0, job_r.vm} : 33'd0);
  assign s_val = (g > {1'b0, cfg.map_var_min}) ? g : {1'b0, cfg.map_var_min};
  // Squared distance is Q32.32; scaling by 2^8 lines it up with threshold^2 times variance.
  assign pass  = ({lhs_r, 8'b0} <= {7'b0, rhs_r});
  assign cnt_inc = (rd_c_r == 16'hFFFF) ? rd_c_r : rd_c_r + 16'd1;
  assign stale = (job_r.max_age != 32'd0) && ((job_r.stamp - rd_s_r) > job_r.max_age);
  assign kill  = (rd_c_r != 16'd0) && ((job_r.kind == eckf_pkg::K_CLEAR) || stale);

  // Rounding half up: add half the divisor before dividing.
  assign numz = {1'b0, pz_r} + {32'b0, vsum_r[32:1]};
  assign numv = {1'b0, pv_r} + {32'b0, vsum_r[32:1]};
  assign div_start = (state_r == eckf_pkg::B_CMP) && pass && (vsum_r != 33'd0);
  assign qz = (vsum_r == 33'd0) ? 32'd0 : quot_z[31:0];
  assign qv = (vsum_r == 33'd0) ? {1'b0, rd_v_r} : quot_v;
  assign zn = neg_r ? rd_h_r - qz : rd_h_r + qz;

  eckf_div u_div_z (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (numz),
    .den  (vsum_r),
    .busy (z_busy),
    .quot (quot_z)
  );

  eckf_div u_div_v (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (numv),
    .den  (vsum_r),
    .busy (v_busy),
    .quot (quot_v)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eckf_pkg::B_INIT: begin
        if (swp_r == LAST) begin
          state_nxt = eckf_pkg::B_IDLE;
        end
      end
      eckf_pkg::B_IDLE: begin
        if (q_pop) begin
          case (q_data.kind)
            eckf_pkg::K_FUSE: begin
              state_nxt = eckf_pkg::B_RD;
            end
            eckf_pkg::K_PRUNE, eckf_pkg::K_CLEAR: begin
              state_nxt = eckf_pkg::B_SW_RD;
            end
            default: begin
              state_nxt = eckf_pkg::B_IDLE;
            end
          endcase
        end
      end
      eckf_pkg::B_RD: begin
        state_nxt = eckf_pkg::B_GATE;
      end
      eckf_pkg::B_GATE: begin
        if (rd_c_r != 16'd0) begin
          state_nxt = eckf_pkg::B_MUL;
        end else if (res_ok) begin
          state_nxt = eckf_pkg::B_IDLE;
        end
      end
      eckf_pkg::B_MUL: begin
        state_nxt = eckf_pkg::B_CMP;
      end
      eckf_pkg::B_CMP: begin
        if (!pass) begin
          if (res_ok) begin
            state_nxt = eckf_pkg::B_IDLE;
          end
        end else if (vsum_r == 33'd0) begin
          state_nxt = eckf_pkg::B_UPD;
        end else begin
          state_nxt = eckf_pkg::B_DIV;
        end
      end
      eckf_pkg::B_DIV: begin
        if (!z_busy && !v_busy) begin
          state_nxt = eckf_pkg::B_UPD;
        end
      end
      eckf_pkg::B_UPD: begin
        if (res_ok) begin
          state_nxt = eckf_pkg::B_IDLE;
        end
      end
      eckf_pkg::B_SW_RD: begin
        state_nxt = eckf_pkg::B_SW_CHK;
      end
      eckf_pkg::B_SW_CHK: begin
        state_nxt = (swp_r == LAST) ? eckf_pkg::B_SW_DONE : eckf_pkg::B_SW_RD;
      end
      eckf_pkg::B_SW_DONE: begin
        if (res_ok) begin
          state_nxt = eckf_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = eckf_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    mem_re = 1'b0;
    mem_we = 1'b0;
    cnt_we = 1'b0;
    wr_h = job_r.zm;
    wr_v = rd_v_r;
    wr_s = job_r.stamp;
    wr_c = cnt_inc;
    res_we = 1'b0;
    res_item = '0;
    res_item.cell_index = 12'(job_r.idx);
    swp_nxt = swp_r;
    emp_nxt = emp_r;
    case (state_r)
      eckf_pkg::B_INIT: begin
        cnt_we = 1'b1;
        wr_c = 16'd0;
        swp_nxt = (swp_r == LAST) ? '0 : swp_r + 1'b1;
      end
      eckf_pkg::B_IDLE: begin
        q_pop = q_valid && ((q_data.kind != eckf_pkg::K_OUTSIDE) || res_ok);
        swp_nxt = '0;
        emp_nxt = '0;
        if (q_pop && q_data.kind == eckf_pkg::K_OUTSIDE) begin
          res_we = 1'b1;
          res_item = '0;
          res_item.status = eckf_pkg::ST_OUTSIDE;
        end
      end
      eckf_pkg::B_RD: begin
        mem_re = 1'b1;
      end
      eckf_pkg::B_GATE: begin
        if (rd_c_r == 16'd0 && res_ok) begin
          // Empty cell: seed it from the measurement.
          mem_we = 1'b1;
          wr_h = job_r.zm;
          wr_v = eckf_pkg::clamp_var({1'b0, job_r.vm}, cfg.map_var_min, cfg.map_var_max);
          wr_c = 16'd1;
          res_we = 1'b1;
          res_item.status = eckf_pkg::ST_SEEDED;
        end
      end
      eckf_pkg::B_CMP: begin
        if (!pass && res_ok) begin
          // Outlier: keep the height, inflate the variance.
          mem_we = 1'b1;
          wr_h = rd_h_r;
          wr_v = eckf_pkg::clamp_var({1'b0, rd_v_r} + {1'b0, cfg.outlier_noise},
                                     cfg.map_var_min, cfg.map_var_max);
          res_we = 1'b1;
          res_item.status = eckf_pkg::ST_OUTLIER;
        end
      end
      eckf_pkg::B_UPD: begin
        if (res_ok) begin
          mem_we = 1'b1;
          wr_h = zn;
          wr_v = eckf_pkg::clamp_var(qv, cfg.map_var_min, cfg.map_var_max);
          res_we = 1'b1;
          res_item.status = eckf_pkg::ST_FUSED;
        end
      end
      eckf_pkg::B_SW_RD: begin
        mem_re = 1'b1;
      end
      eckf_pkg::B_SW_CHK: begin
        if (kill) begin
          cnt_we = 1'b1;
          wr_c = 16'd0;
          emp_nxt = emp_r + 1'b1;
        end
        swp_nxt = (swp_r == LAST) ? '0 : swp_r + 1'b1;
      end
      eckf_pkg::B_SW_DONE: begin
        if (res_ok) begin
          res_we = 1'b1;
          res_item = '0;
          res_item.status = (job_r.kind == eckf_pkg::K_CLEAR) ? eckf_pkg::ST_CLEARED
                                                             : eckf_pkg::ST_PRUNED;
          res_item.cells_emptied = 13'(emp_r);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    if (mem_we) begin
      res_item.cell_height = wr_h;
      res_item.cell_variance = wr_v;
      res_item.cell_count = wr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      h_mem[addr] <= wr_h;
      v_mem[addr] <= wr_v;
      s_mem[addr] <= wr_s;
    end
    if (mem_we || cnt_we) begin
      c_mem[addr] <= wr_c;
    end
    if (mem_re) begin
      rd_h_r <= h_mem[addr];
      rd_v_r <= v_mem[addr];
      rd_s_r <= s_mem[addr];
      rd_c_r <= c_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eckf_pkg::B_INIT;
      swp_r <= '0;
      emp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      swp_r <= swp_nxt;
      emp_r <= emp_nxt;
      if (res_we) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_we) begin
      out_item_r <= res_item;
    end
    if (q_pop) begin
      job_r <= q_data;
    end
    if (state_r == eckf_pkg::B_GATE) begin
      neg_r <= dz[32];
      mag_r <= mag;
      s_r <= s_val;
      thr2_r <= cfg.gate_threshold * cfg.gate_threshold;
    end
    if (state_r == eckf_pkg::B_MUL) begin
      lhs_r <= mag_r * mag_r;
      rhs_r <= thr2_r * s_r;
      pz_r <= mag_r * rd_v_r;
      pv_r <= rd_v_r * job_r.vm;
      vsum_r <= {1'b0, rd_v_r} + {1'b0, job_r.vm};
    end
  end

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> (!out_valid_r || pop))
    else $error("result written over an untaken result");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == eckf_pkg::B_DIV) |-> (z_busy == v_busy))
    else $error("the two dividers fell out of step");

  a_fused_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == eckf_pkg::B_UPD) |-> (wr_c != 16'd0))
    else $error("fused cell left with a zero count");

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == eckf_pkg::B_INIT) |-> !res_we)
    else $error("result produced during the clearing pass");

endmodule

FILE: hdl/elevation_cell_kalman_fusion.sv
// An item that updates an occupied cell runs through the 33-step dividers unless the variance
// sum is zero; a seed, an outlier and an outside-grid item bypass them. Prune and clear
// walk every cell, reading and then checking each in turn. The update engine takes one job
// at a time; the front end keeps taking items meanwhile until the queue and front fill up.
// Reset: synchronous, active low; registers return to defaults and a clearing pass over all
// GRID_X*GRID_Y cells empties the count store while full stays high.
module elevation_cell_kalman_fusion #(
  parameter int unsigned GRID_X = eckf_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = eckf_pkg::GRID_Y_DEF,
  parameter logic [31:0] MEAS_VAR_MIN = eckf_pkg::MEAS_VAR_MIN_DEF,
  parameter logic [31:0] MEAS_VAR_MAX = eckf_pkg::MEAS_VAR_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  eckf_pkg::in_item_t               in_item,
  output logic                             empty,
  input  logic                             pop,
  output eckf_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [eckf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  // The user must write the configuration registers only while the block is idle; the block
  // itself does not enforce it, so the front and the back read them without any hand-off.
  eckf_pkg::cfg_t cfg_r, cfg_nxt;

  // Classified jobs travel from the front end to the back end through a two-entry queue,
  // so a stalled result consumer stops item intake only once the queue and the front fill up.
  logic           q_push, q_full, q_pop, q_valid;
  eckf_pkg::job_t q_in, q_head;
  logic           init_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (eckf_pkg::cfg_reg_t'(cfg_index))
        eckf_pkg::CFG_X_ORIGIN: begin
          cfg_nxt.x_origin = cfg_data;
        end
        eckf_pkg::CFG_Y_ORIGIN: begin
          cfg_nxt.y_origin = cfg_data;
        end
        eckf_pkg::CFG_CELLS_PER_M: begin
          cfg_nxt.cells_per_metre = cfg_data;
        end
        eckf_pkg::CFG_GATE_THRESHOLD: begin
          cfg_nxt.gate_threshold = cfg_data[15:0];
        end
        eckf_pkg::CFG_GATE_USES_MEAS: begin
          cfg_nxt.gate_uses_measurement = cfg_data[0];
        end
        eckf_pkg::CFG_OUTLIER_NOISE: begin
          cfg_nxt.outlier_noise = cfg_data;
        end
        eckf_pkg::CFG_MAP_VAR_MIN: begin
          cfg_nxt.map_var_min = cfg_data;
        end
        eckf_pkg::CFG_MAP_VAR_MAX: begin
          cfg_nxt.map_var_max = cfg_data;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= eckf_pkg::X_ORIGIN_RST;
      cfg_r.y_origin <= eckf_pkg::Y_ORIGIN_RST;
      cfg_r.cells_per_metre <= eckf_pkg::CELLS_PER_METRE_RST;
      cfg_r.gate_threshold <= eckf_pkg::GATE_THRESHOLD_RST;
      cfg_r.gate_uses_measurement <= eckf_pkg::GATE_USES_MEAS_RST;
      cfg_r.outlier_noise <= eckf_pkg::OUTLIER_NOISE_RST;
      cfg_r.map_var_min <= eckf_pkg::MAP_VAR_MIN_RST;
      cfg_r.map_var_max <= eckf_pkg::MAP_VAR_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: two register stages that form the cell offsets, multiply them
  // by the inverse cell size and decide between fuse, outside, prune and clear.
  eckf_front #(
    .GRID_X      (GRID_X),
    .GRID_Y      (GRID_Y),
    .MEAS_VAR_MIN(MEAS_VAR_MIN),
    .MEAS_VAR_MAX(MEAS_VAR_MAX)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .hold   (init_busy),
    .push   (push),
    .full   (full),
    .in_item(in_item),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  eckf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: owns the cell stores and does one read-modify-write per fuse
  // item, with the gate and then two dividers working in parallel, or a sweep
  // over every cell for prune and clear. Its result register is the output.
  eckf_back #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the elevation cell fusion block: fuse, prune and clear items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import eckf_pkg::*;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  elevation_cell_kalman_fusion u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The testbench's own copy of the map and of the registers.
  logic [31:0] map_height[4096];
  logic [31:0] map_var[4096];
  logic [31:0] map_stamp[4096];
  logic [15:0] map_count[4096];
  cfg_t        regs;

  out_item_t   pending_results[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;  // chance in percent that the sender idles a cycle
  int          recv_stall_pct = 0; // chance in percent that the receiver stalls a cycle
  logic [31:0] now_ms = 0;         // running frame time used by the random items

  // Raise to the lower bound first, then cut to the upper one, so crossed bounds
  // leave the upper bound in charge.
  function automatic logic [31:0] bound_var(logic [63:0] v, logic [31:0] lo, logic [31:0] hi);
    logic [63:0] t;
    t = (v < lo) ? 64'(lo) : v;
    if (t > hi) begin
      t = 64'(hi);
    end
    return t[31:0];
  endfunction

  // Appends one expected result behind the ones already waiting.
  function automatic void note_result(out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Works out the result that one accepted item causes and updates the map copy.
  function automatic void fuse_predict(in_item_t it);
    out_item_t   r;
    longint      dx, dy, zc, dz;
    logic [127:0] px, py, lhs, rhs, num, q;
    logic [63:0] ix, iy, vm, vc, g, s, vsum, vnew, mag;
    int          idx, n;
    r = '0;
    if (it.mode == MODE_PRUNE || it.mode == MODE_CLEAR) begin
      n = 0;
      for (int i = 0; i < 4096; i++) begin
        // Ages are taken modulo 2^32, so a stamp that went backwards reads as very old.
        if (map_count[i] != 0 && (it.mode == MODE_CLEAR ||
            (it.max_age != 0 && 32'(it.stamp - map_stamp[i]) > it.max_age))) begin
          map_height[i] = '0;
          map_var[i] = '0;
          map_stamp[i] = '0;
          map_count[i] = '0;
          n++;
        end
      end
      r.status = (it.mode == MODE_PRUNE) ? ST_PRUNED : ST_CLEARED;
      r.cells_emptied = 13'(n);
      note_result(r);
      return;
    end
    if (it.mode != MODE_FUSE) begin
      return;
    end
    dx = longint'(it.point_x) - longint'(regs.x_origin);
    dy = longint'(it.point_y) - longint'(regs.y_origin);
    if (dx < 0 || dy < 0) begin
      r.status = ST_OUTSIDE;
      note_result(r);
      return;
    end
    px = 128'(dx) * 128'(regs.cells_per_metre);
    py = 128'(dy) * 128'(regs.cells_per_metre);
    ix = px[95:32];
    iy = py[95:32];
    if (px[127:96] != 0 || py[127:96] != 0 || ix >= 64 || iy >= 64) begin
      r.status = ST_OUTSIDE;
      note_result(r);
      return;
    end
    idx = int'(ix) * 64 + int'(iy);
    vm = bound_var(64'(it.meas_variance), MEAS_VAR_MIN_DEF, MEAS_VAR_MAX_DEF);
    if (map_count[idx] == 0) begin
      // An empty cell takes the measured height as it is and the bounded variance.
      map_height[idx] = it.point_z;
      map_var[idx] = bound_var(vm, regs.map_var_min, regs.map_var_max);
      map_count[idx] = 16'd1;
      r.status = ST_SEEDED;
    end else begin
      zc = longint'($signed(map_height[idx]));
      dz = longint'(it.point_z) - zc;
      mag = (dz < 0) ? 64'(-dz) : 64'(dz);
      vc = 64'(map_var[idx]);
      g = regs.gate_uses_measurement ? vc + vm : vc;
      s = (g > regs.map_var_min) ? g : 64'(regs.map_var_min);
      // Squared gate: dz^2 in Q32.32 scaled to Q24.40 against threshold^2 times variance.
      lhs = (128'(mag) * 128'(mag)) << 8;
      rhs = 128'(regs.gate_threshold) * 128'(regs.gate_threshold) * 128'(s);
      if (lhs <= rhs) begin
        vsum = vc + vm;
        if (vsum != 0) begin
          num = 128'(mag) * 128'(vc) + 128'(vsum >> 1);
          q = num / 128'(vsum);
          zc = (dz < 0) ? zc - longint'(q[63:0]) : zc + longint'(q[63:0]);
          vnew = (vc * vm + (vsum >> 1)) / vsum;
        end else begin
          vnew = vc;
        end
        map_height[idx] = zc[31:0];
        map_var[idx] = bound_var(vnew, regs.map_var_min, regs.map_var_max);
        r.status = ST_FUSED;
      end else begin
        map_var[idx] = bound_var(vc + 64'(regs.outlier_noise), regs.map_var_min,
                                 regs.map_var_max);
        r.status = ST_OUTLIER;
      end
      if (map_count[idx] != 16'hFFFF) begin
        map_count[idx] = map_count[idx] + 16'd1;
      end
    end
    map_stamp[idx] = it.stamp;
    r.cell_index = 12'(idx);
    r.cell_height = map_height[idx];
    r.cell_variance = map_var[idx];
    r.cell_count = map_count[idx];
    note_result(r);
  endfunction

  // Result side: stalls at random and checks every accepted item against the oldest
  // expectation.
  always @(posedge clk) begin
    out_item_t want;
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result item: status %0d index %0d", out_item.status,
                   out_item.cell_index);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.cell_index !== want.cell_index ||
            out_item.cell_height !== want.cell_height ||
            out_item.cell_variance !== want.cell_variance ||
            out_item.cell_count !== want.cell_count ||
            out_item.cells_emptied !== want.cells_emptied) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected st %0d idx %0d h %h v %h n %0d e %0d",
                     want.status, want.cell_index, want.cell_height, want.cell_variance,
                     want.cell_count, want.cells_emptied);
            $display("                 actual   st %0d idx %0d h %h v %h n %0d e %0d",
                     out_item.status, out_item.cell_index, out_item.cell_height,
                     out_item.cell_variance, out_item.cell_count, out_item.cells_emptied);
          end
        end
      end
    end
  end

  // Sends one item; push stays high across back-to-back items and is only lowered
  // for an idle gap or at a drain.
  task automatic send_item(in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    fuse_predict(it);
  endtask

  // Waits until every expected result has come, plus a margin for ignored items.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Writes all eight registers back to back; only called while the block is idle.
  task automatic load_regs(cfg_t c);
    logic [31:0] vals[8];
    vals[CFG_X_ORIGIN] = c.x_origin;
    vals[CFG_Y_ORIGIN] = c.y_origin;
    vals[CFG_CELLS_PER_M] = c.cells_per_metre;
    vals[CFG_GATE_THRESHOLD] = 32'(c.gate_threshold);
    vals[CFG_GATE_USES_MEAS] = 32'(c.gate_uses_measurement);
    vals[CFG_OUTLIER_NOISE] = c.outlier_noise;
    vals[CFG_MAP_VAR_MIN] = c.map_var_min;
    vals[CFG_MAP_VAR_MAX] = c.map_var_max;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
  endtask

  function automatic cfg_t reset_regs();
    cfg_t c;
    c.x_origin = X_ORIGIN_RST;
    c.y_origin = Y_ORIGIN_RST;
    c.cells_per_metre = CELLS_PER_METRE_RST;
    c.gate_threshold = GATE_THRESHOLD_RST;
    c.gate_uses_measurement = GATE_USES_MEAS_RST;
    c.outlier_noise = OUTLIER_NOISE_RST;
    c.map_var_min = MAP_VAR_MIN_RST;
    c.map_var_max = MAP_VAR_MAX_RST;
    return c;
  endfunction

  // World coordinate that lands in (or right next to) the given cell index.
  function automatic logic [31:0] coord_of(int cell_no, logic [31:0] origin, logic [31:0] cpm);
    logic [63:0] d;
    d = ((64'(cell_no) << 32) + 64'($urandom)) / 64'(cpm);
    return origin + d[31:0];
  endfunction

  function automatic in_item_t make_item(mode_t m, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [31:0] v, logic [31:0] st,
                                         logic [31:0] age);
    in_item_t it;
    it.mode = m;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.meas_variance = v;
    it.stamp = st;
    it.max_age = age;
    return it;
  endfunction

  task automatic fuse_cell(int ix, int iy, logic [31:0] z, logic [31:0] v, logic [31:0] st);
    send_item(make_item(MODE_FUSE, coord_of(ix, regs.x_origin, regs.cells_per_metre),
                        coord_of(iy, regs.y_origin, regs.cells_per_metre), z, v, st, 0));
  endtask

  // Directed items at the reset settings: grid edges, seeding, a fuse with no height
  // error, outliers, extreme heights and variances, the ignored mode, and prune and
  // clear including the disabled prune and an age that wraps around.
  task automatic test_directed();
    send_item(make_item(MODE_FUSE, regs.x_origin - 1, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_FUSE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_FUSE, 0, 32'h8000_0000, 0, 0, 0, 0));
    fuse_cell(0, 0, 0, 32'd0, 0);
    fuse_cell(0, 0, 0, 32'hFFFF_FFFF, 0);
    fuse_cell(0, 0, 32'd1000, 32'd1678, 0);
    fuse_cell(0, 0, 32'h7FFF_FFFF, 32'd1678, 0);
    fuse_cell(63, 63, 32'h8000_0000, 32'd16777216, 0);
    fuse_cell(63, 63, 32'h7FFF_FFFF, 32'd16777217, 0);
    fuse_cell(0, 63, 32'h7FFF_FFFF, 32'd1677, 0);
    fuse_cell(63, 0, 32'hFFFF_0000, 32'd5000, 0);
    send_item(make_item(MODE_IGNORE, '1, '1, '1, '1, '1, '1));
    send_item(make_item(MODE_PRUNE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    fuse_cell(0, 0, 32'd200, 32'd20000, 32'd100);
    send_item(make_item(MODE_PRUNE, 0, 0, 0, 0, 32'd200, 32'd50));
    fuse_cell(5, 7, 32'd300, 32'd20000, 32'd1000);
    send_item(make_item(MODE_PRUNE, 0, 0, 0, 0, 32'd0, 32'd1));
    fuse_cell(5, 7, 32'd300, 32'd20000, 32'd1000);
    fuse_cell(9, 9, 32'd300, 32'd20000, 32'd1000);
    send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(MODE_CLEAR, '1, '1, '1, '1, '1, '1));
    drain_results();
  endtask

  // Register settings of one random phase; the extremes are among them.
  function automatic cfg_t phase_regs(int phase);
    cfg_t c;
    c = reset_regs();
    case (phase)
      1: begin
        c.x_origin = 32'h8000_0000;
        c.y_origin = 32'h7FFF_FFFF;
        c.cells_per_metre = 32'hFFFF_FFFF;
        c.gate_threshold = 16'd0;
        c.gate_uses_measurement = 1'b0;
        c.outlier_noise = 32'd0;
      end
      2: begin
        c.gate_threshold = 16'hFFFF;
        c.outlier_noise = 32'hFFFF_FFFF;
        c.map_var_min = 32'd1;
        c.map_var_max = 32'hFFFF_FFFF;
      end
      3: begin
        // Crossed variance bounds; the upper one wins.
        c.x_origin = 32'd0;
        c.y_origin = 32'd0;
        c.cells_per_metre = 32'd1;
        c.map_var_min = 32'hFFFF_FFFF;
        c.map_var_max = 32'd1;
      end
      4, 6: begin
        c.cells_per_metre = $urandom_range(32'h0000_4000, 32'h0040_0000);
        c.gate_threshold = 16'($urandom);
        c.gate_uses_measurement = 1'($urandom);
        c.outlier_noise = $urandom;
        c.map_var_min = $urandom_range(1, 32'h0010_0000);
        c.map_var_max = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
        if (phase == 6) begin
          c.x_origin = $urandom;
          c.y_origin = $urandom;
        end
      end
      5: begin
        c.x_origin = -32'sd2097152;
        c.cells_per_metre = 32'd65536;
        c.gate_threshold = 16'd256;
        c.outlier_noise = 32'd0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Random items: mostly fuses close to the current cell height on a small pool of
  // cells, with a share of raw noise, ignored items, prunes and clears.
  task automatic test_random_phase(int phase, int count);
    int pick, ix, iy, stress;
    logic [31:0] z, v, age;
    stress = phase % 4;
    for (int k = 0; k < count; k++) begin
      // Every fifty items a stretch runs with no idling at all.
      if (k % 50 < 10) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = (stress == 1) ? 72 : (stress == 3) ? 16 : 0;
        recv_stall_pct = (stress == 2) ? 72 : (stress == 3) ? 16 : 0;
      end
      now_ms = now_ms + $urandom_range(0, 40);
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        ix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
        iy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(60, 63);
        z = map_height[ix * 64 + iy];
        if ($urandom_range(0, 9) < 8) begin
          z = z + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end else begin
          z = $urandom;
        end
        v = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1000, 32'h0100_1000);
        fuse_cell(ix, iy, z, v, ($urandom_range(0, 19) == 0) ? $urandom : now_ms);
      end else if (pick < 92) begin
        send_item(make_item(MODE_FUSE, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      end else if (pick < 96) begin
        send_item(make_item(MODE_IGNORE, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      end else if (pick < 98 || (pick < 99 && $urandom_range(0, 1) == 0)) begin
        age = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
        send_item(make_item(MODE_PRUNE, $urandom, $urandom, $urandom, $urandom,
                            ($urandom_range(0, 9) == 0) ? $urandom : now_ms, age));
      end else if (pick == 99) begin
        send_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      end
    end
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) begin
      map_height[i] = '0;
      map_var[i] = '0;
      map_stamp[i] = '0;
      map_count[i] = '0;
    end
    regs = reset_regs();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    for (int p = 0; p < 8; p++) begin
      load_regs(phase_regs(p));
      test_random_phase(p, 180);
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hdl/eckf_pkg.sv
hdl/eckf_front.sv
hdl/eckf_queue.sv
hdl/eckf_div.sv
hdl/eckf_back.sv
hdl/elevation_cell_kalman_fusion.sv
tb/tb_top.sv
